// ===== design/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/msd_pkg.sv =====
// types, codes and constants of the swipe detector
// no dependencies
package msd_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int KIND_W = 3;
  localparam int VAL_W = 32;
  localparam int THR_W = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_NON_AXIS = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SLOT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRACK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POS_Y = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd300;
  localparam logic DIRECTION_RESET = 1'b1;

  localparam int LIFT_ID = -1;
  localparam int MIN_FINGERS = 3;
  localparam logic [1:0] SWIPE_COUNT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_YWR,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic y_write;
    logic scan_issue;
    logic scan_end;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pos_y;
    logic scan_needed;
    logic last_idx;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/multitouch_swipe_detector.sv =====
// top level of the three-finger swipe detector
// depends on msd_pkg, msd_ctrl, msd_dp
//
// channel   | handshake           | payload
// ----------+---------------------+------------------------------
// input     | in_valid, in_ready  | kind, event_value
// output    | out_valid, out_ready| forward, swipe_trigger
// config    | cfg_we              | cfg_index, cfg_data
//
// one word at a time: most kinds pass through exec and done, a y position
// also writes its position, and one that scans reads every slot (one slot per
// cycle through the position memory read port)
// the next word is taken once the result sits in the output register
// a stalled output holds the sequencer in its last state
// synchronous reset clears slots, counts and flags, no clearing pass
module multitouch_swipe_detector #(
  parameter int NUM_SLOTS = msd_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [msd_pkg::KIND_W-1:0]       kind,
  input  logic signed [msd_pkg::VAL_W-1:0] event_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             forward,
  output logic                             swipe_trigger,
  input  logic                             cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msd_pkg::THR_W-1:0]        cfg_data
);

  msd_pkg::dp_cmd_t  cmd;
  msd_pkg::dp_stat_t stat;

  msd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msd_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .kind          (kind),
    .event_value   (event_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .forward       (forward),
    .swipe_trigger (swipe_trigger)
  );

endmodule

// ===== design/msd_ctrl.sv =====
// sequencer of the swipe detector
// depends on msd_pkg
module msd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  msd_pkg::dp_stat_t stat,
  output msd_pkg::dp_cmd_t  cmd
);

  msd_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      msd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = msd_pkg::ST_EXEC;
        end
      end
      msd_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = stat.is_pos_y ? msd_pkg::ST_YWR : msd_pkg::ST_DONE;
      end
      msd_pkg::ST_YWR: begin
        cmd.y_write = 1'b1;
        state_next = stat.scan_needed ? msd_pkg::ST_SCAN : msd_pkg::ST_DONE;
      end
      msd_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.last_idx) begin
          state_next = msd_pkg::ST_SCAN_END;
        end
      end
      msd_pkg::ST_SCAN_END: begin
        cmd.scan_end = 1'b1;
        state_next = msd_pkg::ST_DONE;
      end
      msd_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = msd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = msd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/msd_dp.sv =====
// slot state, position memories, scan counter and output register
// depends on msd_pkg
module msd_dp #(
  parameter int NUM_SLOTS = msd_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [msd_pkg::KIND_W-1:0]      kind,
  input  logic signed [msd_pkg::VAL_W-1:0] event_value,
  input  logic                            cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msd_pkg::THR_W-1:0]       cfg_data,
  input  msd_pkg::dp_cmd_t                cmd,
  output msd_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            forward,
  output logic                            swipe_trigger
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int FC_W = $clog2(NUM_SLOTS + 1);

  logic [msd_pkg::THR_W-1:0] threshold;
  logic                      dir_down;

  logic [msd_pkg::KIND_W-1:0] kind_q;
  logic [msd_pkg::VAL_W-1:0]  value_q;

  logic [SLOT_W-1:0]    sel;
  logic [FC_W-1:0]      finger_count;
  logic                 triggered;
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] y_valid;

  logic [msd_pkg::VAL_W-1:0] start_mem [NUM_SLOTS];
  logic [msd_pkg::VAL_W-1:0] cur_mem [NUM_SLOTS];
  logic [msd_pkg::VAL_W-1:0] start_q;
  logic [msd_pkg::VAL_W-1:0] cur_q;
  logic [SLOT_W-1:0]         rd_addr;

  logic [SLOT_W-1:0] idx;
  logic              tag_q;
  logic              cmp_v;
  logic [1:0]        hits;
  logic              scan_done;

  logic                      is_lift;
  logic                      start_unset;
  logic signed [msd_pkg::VAL_W:0] diff;
  logic                      hit;
  logic                      fire;
  logic                      trig_new;
  logic                      enough_fingers;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= msd_pkg::THRESHOLD_RESET;
      dir_down <= msd_pkg::DIRECTION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        msd_pkg::REG_THRESHOLD: threshold <= cfg_data;
        msd_pkg::REG_DIRECTION: dir_down <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input word hold
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q <= kind;
      value_q <= event_value;
    end
  end

  assign is_lift = ($signed(value_q) == msd_pkg::LIFT_ID);
  assign enough_fingers = (finger_count >= FC_W'(msd_pkg::MIN_FINGERS));

  // slot select, press and lift
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
      finger_count <= '0;
      triggered <= 1'b0;
      active <= '0;
      y_valid <= '0;
    end else begin
      if (cmd.exec && kind_q == msd_pkg::KIND_SLOT) begin
        if (value_q[msd_pkg::VAL_W-1]) begin
          sel <= '0;
        end else if (value_q >= msd_pkg::VAL_W'(NUM_SLOTS)) begin
          sel <= SLOT_W'(NUM_SLOTS - 1);
        end else begin
          sel <= value_q[SLOT_W-1:0];
        end
      end
      if (cmd.exec && kind_q == msd_pkg::KIND_TRACK) begin
        y_valid[sel] <= 1'b0;
        if (!is_lift) begin
          active[sel] <= 1'b1;
          if (!active[sel]) begin
            finger_count <= finger_count + FC_W'(1);
          end
        end else begin
          active[sel] <= 1'b0;
          if (active[sel] && finger_count != '0) begin
            finger_count <= finger_count - FC_W'(1);
            if (finger_count == FC_W'(1)) begin
              triggered <= 1'b0;
            end
          end else if (finger_count == '0) begin
            triggered <= 1'b0;
          end
        end
      end
      if (cmd.y_write) begin
        y_valid[sel] <= 1'b1;
      end
      if (cmd.finish) begin
        triggered <= trig_new;
      end
    end
  end

  // position memories, registered read
  assign rd_addr = cmd.scan_issue ? idx : sel;
  assign start_unset = !y_valid[sel] || (start_q == '0);

  always_ff @(posedge clk) begin
    if (cmd.y_write) begin
      cur_mem[sel] <= value_q;
      if (start_unset) begin
        start_mem[sel] <= value_q;
      end
    end
    start_q <= start_mem[rd_addr];
    cur_q <= cur_mem[rd_addr];
  end

  // slot scan
  always_comb begin
    if (dir_down) begin
      diff = $signed({cur_q[msd_pkg::VAL_W-1], cur_q})
           - $signed({start_q[msd_pkg::VAL_W-1], start_q});
    end else begin
      diff = $signed({start_q[msd_pkg::VAL_W-1], start_q})
           - $signed({cur_q[msd_pkg::VAL_W-1], cur_q});
    end
    hit = tag_q && (diff > $signed({{(msd_pkg::VAL_W + 1 - msd_pkg::THR_W){1'b0}}, threshold}));
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      tag_q <= active[idx] & y_valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      cmp_v <= 1'b0;
      hits <= '0;
      scan_done <= 1'b0;
    end else begin
      cmp_v <= cmd.scan_issue;
      if (cmd.latch) begin
        scan_done <= 1'b0;
      end
      if (cmd.y_write) begin
        idx <= '0;
        hits <= '0;
      end else begin
        if (cmd.scan_issue) begin
          idx <= idx + SLOT_W'(1);
        end
        if (cmp_v && hit && hits != msd_pkg::SWIPE_COUNT) begin
          hits <= hits + 2'd1;
        end
      end
      if (cmd.scan_end) begin
        scan_done <= 1'b1;
      end
    end
  end

  // result
  assign fire = scan_done && (hits == msd_pkg::SWIPE_COUNT);
  assign trig_new = triggered | fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      forward <= !(trig_new && enough_fingers);
      swipe_trigger <= fire;
    end
  end

  assign stat.is_pos_y = (kind_q == msd_pkg::KIND_POS_Y);
  assign stat.scan_needed = enough_fingers && !triggered;
  assign stat.last_idx = (idx == SLOT_W'(NUM_SLOTS - 1));
  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== design/msd_checker.sv =====
// port checker for the swipe detector, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module msd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic forward,
  input logic swipe_trigger
);

  // a firing word is always dropped
  `ASSERT_IMPLIES(a_trigger_drops, clk, rst, out_valid && swipe_trigger, !forward)

  // one word in flight at a time
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)

  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(forward) && $stable(swipe_trigger))

endmodule

bind multitouch_swipe_detector msd_checker u_msd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .forward       (forward),
  .swipe_trigger (swipe_trigger)
);
